[hdl/mhpq_pkg.sv]
// shared constants, types and helpers for the max-heap priority queue
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W       = 4;

    // command field codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // datapath operation codes
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_INS_START = 4'd1;
    localparam logic [OP_W-1:0] OP_DEL_START = 4'd2;
    localparam logic [OP_W-1:0] OP_FULL      = 4'd3;
    localparam logic [OP_W-1:0] OP_EMPTY     = 4'd4;
    localparam logic [OP_W-1:0] OP_UP_READ   = 4'd5;
    localparam logic [OP_W-1:0] OP_UP_CMP    = 4'd6;
    localparam logic [OP_W-1:0] OP_UP_FIN    = 4'd7;
    localparam logic [OP_W-1:0] OP_DN_LOAD   = 4'd8;
    localparam logic [OP_W-1:0] OP_DN_READ   = 4'd9;
    localparam logic [OP_W-1:0] OP_DN_CMP    = 4'd10;
    localparam logic [OP_W-1:0] OP_RESULT    = 4'd11;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [ADDR_W-1:0]            addr_t;
    typedef logic [COUNT_W-1:0]           count_t;
    typedef logic [OP_W-1:0]              op_t;

    // flags from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic up_move;
        logic parent_root;
        logic dn_move;
    } flags_t;

    // sign-extend or truncate the input value into a heap entry
    function automatic data_t ext_value(input logic signed [VALUE_W-1:0] v);
        logic [DATA_WIDTH+VALUE_W-1:0] wide;
        wide = {{DATA_WIDTH{v[VALUE_W-1]}}, v};
        return wide[DATA_WIDTH-1:0];
    endfunction

    // low bits of an entry, zero-filled when the entry is narrower
    function automatic logic [VALUE_W-1:0] to_removed(input data_t d);
        logic [DATA_WIDTH+VALUE_W-1:0] wide;
        wide = {{VALUE_W{1'b0}}, d};
        return wide[VALUE_W-1:0];
    endfunction

endpackage

[hdl/mhpq_if.sv]
// valid/ready channel interfaces for requests and responses
// depends on mhpq_pkg
`timescale 1ns / 1ps

interface mhpq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [mhpq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface mhpq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [mhpq_pkg::STATUS_W-1:0]        status;
    logic signed [mhpq_pkg::VALUE_W-1:0]  removed_value;
    logic [mhpq_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

[hdl/mhpq_datapath.sv]
// heap storage, sift registers, compare logic and response payload registers
// depends on mhpq_pkg; driven by mhpq_ctrl through operation codes
`timescale 1ns / 1ps

module mhpq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mhpq_pkg::op_t                       op,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] value,
    output mhpq_pkg::flags_t                    flags,
    output logic [mhpq_pkg::STATUS_W-1:0]       status,
    output logic signed [mhpq_pkg::VALUE_W-1:0] removed_value,
    output mhpq_pkg::count_t                    entry_count
);

    localparam int CHILD_W = mhpq_pkg::ADDR_W + 2;

    mhpq_pkg::data_t mem [mhpq_pkg::CAPACITY];

    mhpq_pkg::count_t count_reg, count_next;
    mhpq_pkg::addr_t  pos_reg, pos_next;
    mhpq_pkg::data_t  hold_reg, hold_next;
    mhpq_pkg::data_t  removed_reg, removed_next;
    logic [mhpq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    logic [mhpq_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [mhpq_pkg::VALUE_W-1:0]        out_removed_reg, out_removed_next;
    mhpq_pkg::count_t                    out_count_reg, out_count_next;

    mhpq_pkg::addr_t  rd_a_addr, rd_b_addr, wr_addr;
    mhpq_pkg::data_t  rd_a_data_reg, rd_b_data_reg, wr_data;
    logic             wr_en;

    mhpq_pkg::addr_t  parent;
    mhpq_pkg::count_t last_idx;
    logic [CHILD_W-1:0] left_idx, right_idx, count_wide;
    logic             left_ok, right_ok, take_left, take_right;
    mhpq_pkg::data_t  best_val;

    // tree navigation
    assign parent     = (pos_reg - mhpq_pkg::ADDR_W'(1)) >> 1;
    assign last_idx   = count_reg - mhpq_pkg::COUNT_W'(1);
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + CHILD_W'(1);
    assign count_wide = CHILD_W'(count_reg);
    assign left_ok    = left_idx < count_wide;
    assign right_ok   = right_idx < count_wide;

    // pick the strictly largest of hold, left child, right child; left wins ties
    always_comb
    begin
        best_val  = hold_reg;
        take_left = 1'b0;
        if (left_ok && (hold_reg < rd_a_data_reg))
        begin
            best_val  = rd_a_data_reg;
            take_left = 1'b1;
        end
        take_right = right_ok && (best_val < rd_b_data_reg);
    end

    assign flags.full        = (count_reg == mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY));
    assign flags.empty       = (count_reg == '0);
    assign flags.up_move     = (rd_a_data_reg < hold_reg);
    assign flags.parent_root = (parent == '0);
    assign flags.dn_move     = take_left || take_right;

    always_comb
    begin
        count_next       = count_reg;
        pos_next         = pos_reg;
        hold_next        = hold_reg;
        removed_next     = removed_reg;
        res_status_next  = res_status_reg;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;
        rd_a_addr        = parent;
        rd_b_addr        = parent;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_data          = hold_reg;
        unique case (op)
            mhpq_pkg::OP_NONE:
            begin
            end
            mhpq_pkg::OP_INS_START:
            begin
                hold_next       = mhpq_pkg::ext_value(value);
                pos_next        = count_reg[mhpq_pkg::ADDR_W-1:0];
                count_next      = count_reg + mhpq_pkg::COUNT_W'(1);
                removed_next    = '0;
                res_status_next = mhpq_pkg::STAT_OK;
            end
            mhpq_pkg::OP_DEL_START:
            begin
                rd_a_addr       = '0;
                rd_b_addr       = last_idx[mhpq_pkg::ADDR_W-1:0];
                count_next      = last_idx;
                res_status_next = mhpq_pkg::STAT_OK;
            end
            mhpq_pkg::OP_FULL:
            begin
                removed_next    = '0;
                res_status_next = mhpq_pkg::STAT_FULL;
            end
            mhpq_pkg::OP_EMPTY:
            begin
                removed_next    = '0;
                res_status_next = mhpq_pkg::STAT_EMPTY;
            end
            mhpq_pkg::OP_UP_READ:
            begin
                rd_a_addr = parent;
            end
            mhpq_pkg::OP_UP_CMP:
            begin
                wr_en = 1'b1;
                if (flags.up_move)
                begin
                    wr_data  = rd_a_data_reg;
                    pos_next = parent;
                end
            end
            mhpq_pkg::OP_UP_FIN:
            begin
                wr_en = 1'b1;
            end
            mhpq_pkg::OP_DN_LOAD:
            begin
                removed_next = rd_a_data_reg;
                hold_next    = rd_b_data_reg;
                pos_next     = '0;
            end
            mhpq_pkg::OP_DN_READ:
            begin
                rd_a_addr = left_idx[mhpq_pkg::ADDR_W-1:0];
                rd_b_addr = right_idx[mhpq_pkg::ADDR_W-1:0];
            end
            mhpq_pkg::OP_DN_CMP:
            begin
                wr_en = 1'b1;
                if (take_right)
                begin
                    wr_data  = rd_b_data_reg;
                    pos_next = right_idx[mhpq_pkg::ADDR_W-1:0];
                end
                else if (take_left)
                begin
                    wr_data  = rd_a_data_reg;
                    pos_next = left_idx[mhpq_pkg::ADDR_W-1:0];
                end
            end
            mhpq_pkg::OP_RESULT:
            begin
                out_status_next  = res_status_reg;
                out_removed_next = mhpq_pkg::to_removed(removed_reg);
                out_count_next   = count_reg;
            end
            default:
            begin
            end
        endcase
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data_reg <= mem[rd_a_addr];
        rd_b_data_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        hold_reg        <= hold_next;
        removed_reg     <= removed_next;
        res_status_reg  <= res_status_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
    end

    assign status        = out_status_reg;
    assign removed_value = out_removed_reg;
    assign entry_count   = out_count_reg;

endmodule

[hdl/mhpq_ctrl.sv]
// sequencing state machine and response valid register
// depends on mhpq_pkg; drives mhpq_datapath through operation codes
`timescale 1ns / 1ps

module mhpq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_command,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  mhpq_pkg::flags_t flags,
    output mhpq_pkg::op_t    op
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_UP_FIN  = 3'd3;
    localparam logic [2:0] S_DN_LOAD = 3'd4;
    localparam logic [2:0] S_DN_RD   = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        op             = mhpq_pkg::OP_NONE;
        out_valid_next = out_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_command == mhpq_pkg::CMD_INSERT)
                    begin
                        if (flags.full)
                        begin
                            op         = mhpq_pkg::OP_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            op         = mhpq_pkg::OP_INS_START;
                            state_next = flags.empty ? S_UP_FIN : S_UP_RD;
                        end
                    end
                    else if (flags.empty)
                    begin
                        op         = mhpq_pkg::OP_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        op         = mhpq_pkg::OP_DEL_START;
                        state_next = S_DN_LOAD;
                    end
                end
            end
            S_UP_RD:
            begin
                op         = mhpq_pkg::OP_UP_READ;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                op = mhpq_pkg::OP_UP_CMP;
                if (flags.up_move)
                begin
                    state_next = flags.parent_root ? S_UP_FIN : S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UP_FIN:
            begin
                op         = mhpq_pkg::OP_UP_FIN;
                state_next = S_DONE;
            end
            S_DN_LOAD:
            begin
                op         = mhpq_pkg::OP_DN_LOAD;
                state_next = flags.empty ? S_DONE : S_DN_RD;
            end
            S_DN_RD:
            begin
                op         = mhpq_pkg::OP_DN_READ;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                op         = mhpq_pkg::OP_DN_CMP;
                state_next = flags.dn_move ? S_DN_RD : S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    op             = mhpq_pkg::OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

[hdl/max_heap_priority_queue.sv]
// binary max-heap priority queue, top level; uses mhpq_pkg, mhpq_if, mhpq_ctrl, mhpq_datapath
// a full insert or an empty delete goes straight to the response; an insert climbs one level
// per compare until the parent is not smaller or it reaches the root, and a delete moves the
// last entry to the root and descends one level per compare, unless it took the last entry
// throughput: one item in flight; a stalled response waits in its register while the next runs
// reset: asynchronous active low, empties the queue at once; heap memory is not cleared
`timescale 1ns / 1ps

module max_heap_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    mhpq_req_if.sink    req,
    mhpq_rsp_if.source  rsp
);

    mhpq_pkg::op_t    op;
    mhpq_pkg::flags_t flags;

    // sequencer: handshake, state walk, response valid
    mhpq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .flags       (flags),
        .op          (op)
    );

    // storage, compare logic and response payload
    mhpq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .value         (req.value),
        .flags         (flags),
        .status        (rsp.status),
        .removed_value (rsp.removed_value),
        .entry_count   (rsp.entry_count)
    );

endmodule

[hdl/mhpq_checker.sv]
// port-level checks for the max-heap priority queue, bound to the top level
// depends on mhpq_pkg and max_heap_priority_queue
`timescale 1ns / 1ps

module mhpq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                req_valid,
    input logic                                req_ready,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [mhpq_pkg::STATUS_W-1:0]       rsp_status,
    input logic signed [mhpq_pkg::VALUE_W-1:0] rsp_removed_value,
    input mhpq_pkg::count_t                    rsp_entry_count
);

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_removed_value) && $stable(rsp_entry_count))
        else $error("stalled response changed");

    // one request at a time: no transfer right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // empty delete reports an empty queue and no value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == mhpq_pkg::STAT_EMPTY) |->
            (rsp_entry_count == '0) && (rsp_removed_value == '0))
        else $error("bad empty response");

    // dropped insert reports a full queue and no value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == mhpq_pkg::STAT_FULL) |->
            (rsp_entry_count == mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY))
            && (rsp_removed_value == '0))
        else $error("bad full response");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_removed_value (rsp.removed_value),
    .rsp_entry_count   (rsp.entry_count)
);

[tb/tb_max_heap_priority_queue.sv]
// self-checking testbench for the max-heap priority queue: directed table, random traffic,
// fill to capacity and a partial drain, with random idling on both channels and a long hold-off
// depends on mhpq_pkg, mhpq_if and max_heap_priority_queue from hdl
`timescale 1ns / 1ps

module tb_max_heap_priority_queue;

    // quiet cycles allowed before the run is declared hung; well above the response hold-off
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RSP_HOLD_CYCLES = 300;
    // settle time at the end, a bit more than the worst sift walk
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_PRINTED     = 100;

    // one response as seen on the rsp channel
    typedef struct packed {
        logic [mhpq_pkg::STATUS_W-1:0]       status;
        logic signed [mhpq_pkg::VALUE_W-1:0] removed;
        mhpq_pkg::count_t                    count;
    } heap_result_t;

    // one row of the directed table; known rows carry a hand-written response
    typedef struct packed {
        logic                                cmd;
        logic signed [mhpq_pkg::VALUE_W-1:0] val;
        logic                                known;
        heap_result_t                        res;
    } heap_row_t;

    localparam int NUM_ROWS = 25;

    // min/max extremes, empty and refill, ties, ignored value on delete
    localparam heap_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{mhpq_pkg::CMD_DELETE, 32'sd0,        1'b1, '{mhpq_pkg::STAT_EMPTY, 32'sd0, 11'd0}},
        '{mhpq_pkg::CMD_INSERT, 32'sh7FFFFFFF, 1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd1}},
        '{mhpq_pkg::CMD_INSERT, 32'sh80000000, 1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd2}},
        '{mhpq_pkg::CMD_DELETE, 32'sd0,        1'b1, '{mhpq_pkg::STAT_OK, 32'sh7FFFFFFF, 11'd1}},
        '{mhpq_pkg::CMD_DELETE, 32'sd0,        1'b1, '{mhpq_pkg::STAT_OK, 32'sh80000000, 11'd0}},
        '{mhpq_pkg::CMD_DELETE, 32'shFFFFFFFF, 1'b1, '{mhpq_pkg::STAT_EMPTY, 32'sd0, 11'd0}},
        '{mhpq_pkg::CMD_INSERT, 32'sd0,        1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd1}},
        '{mhpq_pkg::CMD_INSERT, 32'shFFFFFFFF, 1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd2}},
        '{mhpq_pkg::CMD_INSERT, 32'sd1,        1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd3}},
        '{mhpq_pkg::CMD_INSERT, 32'sd1,        1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd4}},
        '{mhpq_pkg::CMD_INSERT, 32'sd5,        1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd5}},
        '{mhpq_pkg::CMD_INSERT, 32'sd5,        1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd6}},
        '{mhpq_pkg::CMD_INSERT, 32'sd3,        1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd7}},
        '{mhpq_pkg::CMD_INSERT, 32'sh80000000, 1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd8}},
        '{mhpq_pkg::CMD_INSERT, 32'sh7FFFFFFF, 1'b1, '{mhpq_pkg::STAT_OK, 32'sd0, 11'd9}},
        '{mhpq_pkg::CMD_DELETE, 32'sh12345678, 1'b1, '{mhpq_pkg::STAT_OK, 32'sh7FFFFFFF, 11'd8}},
        '{mhpq_pkg::CMD_DELETE, 32'sh80000000, 1'b0, '0},
        '{mhpq_pkg::CMD_DELETE, 32'sh7FFFFFFF, 1'b0, '0},
        '{mhpq_pkg::CMD_DELETE, 32'sd0,        1'b0, '0},
        '{mhpq_pkg::CMD_DELETE, 32'shFFFFFFFF, 1'b0, '0},
        '{mhpq_pkg::CMD_DELETE, 32'sd0,        1'b0, '0},
        '{mhpq_pkg::CMD_DELETE, 32'sh55555555, 1'b0, '0},
        '{mhpq_pkg::CMD_DELETE, 32'shAAAAAAAA, 1'b0, '0},
        '{mhpq_pkg::CMD_DELETE, 32'sd0,        1'b1, '{mhpq_pkg::STAT_OK, 32'sh80000000, 11'd0}},
        '{mhpq_pkg::CMD_DELETE, 32'sd0,        1'b1, '{mhpq_pkg::STAT_EMPTY, 32'sd0, 11'd0}}
    };

    logic clk;
    logic rst_n;

    mhpq_req_if req_ch ();
    mhpq_rsp_if rsp_ch ();

    max_heap_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow heap, kept in step with every accepted request
    mhpq_pkg::data_t heap_mem [mhpq_pkg::CAPACITY];
    int              heap_size;

    // responses still owed by the block, oldest first
    heap_result_t pending_results [$];
    heap_result_t oldest_result;

    int  error_count;
    int  quiet_cycles;
    int  src_idle_pct;
    int  snk_stall_pct;
    // forces rsp ready low for the back-pressure phase
    logic hold_rsp;

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // one line per mismatch, counted; printing capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what,
                                   input logic [mhpq_pkg::VALUE_W-1:0] got,
                                   input logic [mhpq_pkg::VALUE_W-1:0] want);
        if (error_count < MAX_PRINTED)
        begin
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        end
        error_count++;
    endtask

    // applies one request to the shadow heap and returns the response it must produce
    function automatic heap_result_t heap_apply(input logic cmd,
                                                input logic signed [mhpq_pkg::VALUE_W-1:0] val);
        heap_result_t    r;
        int              pos;
        int              parent;
        int              best;
        int              left;
        int              right;
        mhpq_pkg::data_t tmp;
        r        = '0;
        r.status = mhpq_pkg::STAT_OK;
        if (cmd == mhpq_pkg::CMD_INSERT)
        begin
            if (heap_size >= mhpq_pkg::CAPACITY)
            begin
                // full: dropped, heap untouched
                r.status = mhpq_pkg::STAT_FULL;
            end
            else
            begin
                pos           = heap_size;
                heap_mem[pos] = mhpq_pkg::data_t'(val);
                heap_size++;
                // climb while the parent is strictly smaller
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!(heap_mem[parent] < heap_mem[pos]))
                    begin
                        break;
                    end
                    tmp              = heap_mem[parent];
                    heap_mem[parent] = heap_mem[pos];
                    heap_mem[pos]    = tmp;
                    pos              = parent;
                end
            end
        end
        else if (heap_size == 0)
        begin
            r.status = mhpq_pkg::STAT_EMPTY;
        end
        else
        begin
            r.removed   = heap_mem[0];
            heap_size--;
            heap_mem[0] = heap_mem[heap_size];
            pos         = 0;
            // descend to the strictly largest of node and children, left wins a tie
            forever
            begin
                best  = pos;
                left  = 2 * pos + 1;
                right = left + 1;
                if (left < heap_size && heap_mem[best] < heap_mem[left])
                begin
                    best = left;
                end
                if (right < heap_size && heap_mem[best] < heap_mem[right])
                begin
                    best = right;
                end
                if (best == pos)
                begin
                    break;
                end
                tmp            = heap_mem[pos];
                heap_mem[pos]  = heap_mem[best];
                heap_mem[best] = tmp;
                pos            = best;
            end
        end
        r.count = mhpq_pkg::count_t'(heap_size);
        return r;
    endfunction

    // value mix: extremes, a narrow band that makes ties common, and full-range values
    function automatic logic signed [mhpq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3:    return $urandom_range(15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // offers one request, with random idle cycles in front; entered and left just after a
    // falling edge, so valid gets at most one assignment per falling edge
    task automatic send_request(input logic cmd, input logic signed [mhpq_pkg::VALUE_W-1:0] val,
                                input logic known, input heap_result_t known_res);
        heap_result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= val;
        // transfer happens at the first rising edge with ready high
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = heap_apply(cmd, val);
        pending_results.insert(pending_results.size(), known ? known_res : predicted);
        @(negedge clk);
    endtask

    task automatic send_random(input int insert_pct);
        send_request(($urandom_range(99) < insert_pct) ? mhpq_pkg::CMD_INSERT
                                                       : mhpq_pkg::CMD_DELETE,
                     pick_value(), 1'b0, '0);
    endtask

    task automatic run_random(input int num_items, input int insert_pct);
        repeat (num_items)
        begin
            send_random(insert_pct);
        end
    endtask

    // receiver: random stalls, or held low for the whole back-pressure window
    always @(negedge clk)
    begin
        rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= snk_stall_pct);
    end

    // response checker: every transfer on rsp is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected response", mhpq_pkg::VALUE_W'(rsp_ch.status), '0);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp_ch.status !== oldest_result.status)
                begin
                    report_mismatch("status", mhpq_pkg::VALUE_W'(rsp_ch.status),
                                    mhpq_pkg::VALUE_W'(oldest_result.status));
                end
                if (rsp_ch.removed_value !== oldest_result.removed)
                begin
                    report_mismatch("removed_value", rsp_ch.removed_value,
                                    oldest_result.removed);
                end
                if (rsp_ch.entry_count !== oldest_result.count)
                begin
                    report_mismatch("entry_count", mhpq_pkg::VALUE_W'(rsp_ch.entry_count),
                                    mhpq_pkg::VALUE_W'(oldest_result.count));
                end
            end
        end
    end

    // watchdog: any transfer on either channel counts as progress
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL max_heap_priority_queue");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        // known values on every input from time zero
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.command = mhpq_pkg::CMD_INSERT;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        hold_rsp       = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        error_count    = 0;
        quiet_cycles   = 0;
        heap_size      = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, no idling
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_request(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].val,
                         DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].res);
        end

        // mixed traffic, slight bias to insert at first, then even
        run_random(15, 60);
        src_idle_pct  = 51;
        run_random(15, 60);
        src_idle_pct  = 0;
        snk_stall_pct = 51;
        run_random(15, 50);
        src_idle_pct  = 16;
        snk_stall_pct = 16;
        run_random(15, 50);

        // back-pressure: rsp held off while requests keep coming, so req ready must drop
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        fork
            begin
                @(posedge clk);
                hold_rsp = 1'b1;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            run_random(24, 70);
        join

        // fill to capacity, then inserts that must be dropped as full
        src_idle_pct  = 16;
        snk_stall_pct = 16;
        while (heap_size < mhpq_pkg::CAPACITY)
        begin
            send_random(100);
        end
        repeat (4)
        begin
            send_request(mhpq_pkg::CMD_INSERT, pick_value(), 1'b0, '0);
        end
        // churn around the full mark
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_random(8, 50);

        // deletes from the nearly full heap, deep sift-down walks
        snk_stall_pct = 51;
        run_random(16, 0);
        req_ch.valid <= 1'b0;

        // wait for the last responses, then a settle window for stray transfers
        snk_stall_pct = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS max_heap_priority_queue");
        end
        else
        begin
            $display("FAIL max_heap_priority_queue");
        end
        $finish;
    end

endmodule
